FILE: design/vbog_pkg.sv
`default_nettype none
package vbog_pkg;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LAYOUT = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD      = 2'd3
    } status_t;

    // Datapath address source select
    typedef enum logic [1:0] {
        AS_CELL  = 2'd0,
        AS_WALK  = 2'd1,
        AS_SWEEP = 2'd2
    } asel_t;

    // Walk counter init select
    typedef enum logic [1:0] {
        WI_ADD  = 2'd0,
        WI_RUNS = 2'd1
    } winit_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_DECIDE,
        S_REFRD,
        S_REFWT,
        S_RUNRD,
        S_RUNWT,
        S_RUNCHK,
        S_CHKRD,
        S_CHKWT,
        S_CHKCHK,
        S_WRITE,
        S_RMRD,
        S_RMWT,
        S_RMCHK,
        S_DONE,
        S_OUT
    } fsm_state_t;

    typedef struct packed {
        logic   load_req;
        logic   clr_start;
        logic   sweep_step;
        asel_t  asel;
        logic   rd_en;
        logic   wr_en;
        logic   wr_zero;
        logic   ref_load;
        logic   run_init;
        logic   run_probe;
        logic   run_hit;
        logic   walk_init;
        winit_t walk_src;
        logic   walk_step;
        logic   set_status;
        status_t status_val;
        logic   set_found;
        logic   keep_runs;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        req_t  req;
        logic  bad_cell;
        logic  bad_add;
        logic  empty_box;
        logic  sweep_last;
        logic  rd_nonzero;
        logic  rd_eq_ref;
        logic  run_more;
        logic  run_done;
        logic  walk_last;
        logic  ref_zero;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/vbog_datapath.sv
`default_nettype none
module vbog_datapath
    import vbog_pkg::*;
#(
    parameter int MAX_DEPTH = 8,
    parameter int ID_BITS   = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [3:0]    grid_depth,
    input  wire logic [ID_BITS+22:0] req_data,
    input  wire dp_cmd_t       cmd,
    output dp_stat_t           stat,
    output logic [ID_BITS+22:0] result
);
    localparam int CB = $clog2(MAX_DEPTH);
    localparam int AB = 3 * CB;
    localparam int NCELL = 1 << AB;

    logic [ID_BITS-1:0] mem [NCELL];
    logic [ID_BITS-1:0] rd_data_reg;

    logic [ID_BITS+22:0] req_reg;
    logic [4:0] dep_reg;
    logic [AB-1:0] sweep_reg;
    logic [ID_BITS-1:0] ref_reg, found_reg;
    logic [1:0] axis_reg;
    logic dir_reg;
    logic [4:0] probe_reg;
    logic [4:0] lo_reg [3];
    logic [4:0] hi_reg [3];
    logic [4:0] wlo_reg [3];
    logic [4:0] whi_reg [3];
    logic [4:0] wp_reg [3];
    status_t status_reg;
    logic [ID_BITS+22:0] out_reg;

    logic [4:0] c [3];
    logic [4:0] sz [3];
    logic [ID_BITS-1:0] req_id;
    logic [4:0] pa [3];
    logic [AB-1:0] addr;
    logic [4:0] deff;

    assign deff = (grid_depth > 4'(MAX_DEPTH > 15 ? 15 : MAX_DEPTH)
                   && MAX_DEPTH < 16) ? 5'(MAX_DEPTH) : {1'b0, grid_depth};
    // req_data: type[1:0] x y z(3 each) bx by bz(4 each) id
    assign c[0]  = {2'b0, req_reg[4:2]};
    assign c[1]  = {2'b0, req_reg[7:5]};
    assign c[2]  = {2'b0, req_reg[10:8]};
    assign sz[0] = {1'b0, req_reg[14:11]};
    assign sz[1] = {1'b0, req_reg[18:15]};
    assign sz[2] = {1'b0, req_reg[22:19]};
    assign req_id = req_reg[ID_BITS+22:23];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pa[a] = c[a];
        end
        case (cmd.asel)
            AS_WALK:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pa[a] = wp_reg[a];
                end
            end
            AS_CELL:
            begin
                if (probe_reg != 5'h1f)
                begin
                    pa[axis_reg] = probe_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cmd.asel == AS_SWEEP)
        begin
            addr = sweep_reg;
        end
        else
        begin
            addr = {pa[2][CB-1:0], pa[1][CB-1:0], pa[0][CB-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= cmd.wr_zero ? '0 : req_id;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // run probe: next cell along axis, lower side first
    logic [4:0] nlo, nhi;
    assign nlo = lo_reg[axis_reg] - 5'd1;
    assign nhi = hi_reg[axis_reg] + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= '0;
            axis_reg   <= '0;
            dir_reg    <= 1'b0;
            probe_reg  <= 5'h1f;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + AB'(1);
            end
            if (cmd.load_req)
            begin
                status_reg <= ST_OK;
                probe_reg  <= 5'h1f;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_val;
            end
            if (cmd.run_init)
            begin
                axis_reg <= '0;
                dir_reg  <= 1'b0;
            end
            if (cmd.run_probe)
            begin
                probe_reg <= dir_reg ? nhi : nlo;
            end
            if (cmd.run_hit)
            begin
                probe_reg <= 5'h1f;
                // no room on this side counts as a mismatch
                if (!(stat.rd_eq_ref && stat.run_more))
                begin
                    if (dir_reg)
                    begin
                        dir_reg  <= 1'b0;
                        axis_reg <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        dir_reg <= 1'b1;
                    end
                end
            end
            if (cmd.walk_init || cmd.out_load)
            begin
                probe_reg <= 5'h1f;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
            dep_reg <= deff;
        end
        if (cmd.ref_load)
        begin
            ref_reg <= rd_data_reg;
        end
        if (cmd.set_found)
        begin
            found_reg <= ref_reg;
        end
        else if (cmd.load_req)
        begin
            found_reg <= '0;
        end
        if (cmd.run_init)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= c[a];
                hi_reg[a] <= c[a];
            end
        end
        if (cmd.run_hit && stat.rd_eq_ref && stat.run_more)
        begin
            if (dir_reg)
            begin
                hi_reg[axis_reg] <= nhi;
            end
            else
            begin
                lo_reg[axis_reg] <= nlo;
            end
        end
        if (cmd.walk_init)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cmd.walk_src == WI_ADD)
                begin
                    wlo_reg[a] <= c[a];
                    whi_reg[a] <= c[a] + sz[a] - 5'd1;
                    wp_reg[a]  <= c[a];
                end
                else
                begin
                    wlo_reg[a] <= lo_reg[a];
                    whi_reg[a] <= hi_reg[a];
                    wp_reg[a]  <= lo_reg[a];
                end
            end
        end
        else if (cmd.walk_step)
        begin
            if (wp_reg[0] != whi_reg[0])
            begin
                wp_reg[0] <= wp_reg[0] + 5'd1;
            end
            else
            begin
                wp_reg[0] <= wlo_reg[0];
                if (wp_reg[1] != whi_reg[1])
                begin
                    wp_reg[1] <= wp_reg[1] + 5'd1;
                end
                else
                begin
                    wp_reg[1] <= wlo_reg[1];
                    wp_reg[2] <= wp_reg[2] + 5'd1;
                end
            end
        end
        if (cmd.out_load)
        begin
            // box fields only for a successful remove or layout
            if (cmd.keep_runs && status_reg == ST_OK)
            begin
                out_reg <= {4'(hi_reg[2] - lo_reg[2] + 5'd1),
                            4'(hi_reg[1] - lo_reg[1] + 5'd1),
                            4'(hi_reg[0] - lo_reg[0] + 5'd1),
                            lo_reg[2][2:0], lo_reg[1][2:0], lo_reg[0][2:0],
                            found_reg, status_reg};
            end
            else
            begin
                out_reg <= {(ID_BITS+21)'(0), status_reg};
            end
        end
    end

    assign result = out_reg;

    always_comb
    begin
        stat.req        = req_t'(req_reg[1:0]);
        stat.bad_cell   = (dep_reg == 5'd0) || c[0] >= dep_reg
                          || c[1] >= dep_reg || c[2] >= dep_reg;
        stat.bad_add    = (req_id == '0) || (c[0] + sz[0] > dep_reg)
                          || (c[1] + sz[1] > dep_reg) || (c[2] + sz[2] > dep_reg);
        stat.empty_box  = (sz[0] == 5'd0) || (sz[1] == 5'd0) || (sz[2] == 5'd0);
        stat.sweep_last = (sweep_reg == AB'(NCELL - 1));
        stat.rd_nonzero = (rd_data_reg != '0);
        stat.rd_eq_ref  = (rd_data_reg == ref_reg);
        stat.ref_zero   = (rd_data_reg == '0);
        stat.run_done   = (axis_reg == 2'd3);
        stat.run_more   = dir_reg ? (hi_reg[axis_reg] + 5'd1 < dep_reg)
                                  : (lo_reg[axis_reg] != 5'd0);
        stat.walk_last  = (wp_reg[0] == whi_reg[0]) && (wp_reg[1] == whi_reg[1])
                          && (wp_reg[2] == whi_reg[2]);
    end

    // Address only uses wp/probe during its own phases; memory ignores upper bits
    // since coordinates stay below MAX_DEPTH there.
`ifndef SYNTH
    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> wp_reg[2] <= whi_reg[2])
        else $error("walk left box");
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> dep_reg <= 5'(MAX_DEPTH))
        else $error("depth above max");
    a_no_rw_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> cmd.wr_en && cmd.wr_zero)
        else $error("sweep without zero write");
`endif
endmodule
`default_nettype wire

FILE: design/vbog_ctrl.sv
`default_nettype none
module vbog_ctrl
    import vbog_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t   cmd
);
    fsm_state_t state_reg, state_next;
    logic clr_req_reg, clr_req_next;
    logic out_clr_reg, out_clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_req_reg <= 1'b0;
            out_clr_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_req_reg <= clr_req_next;
            out_clr_reg <= out_clr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_req_next  = clr_req_reg | cfg_wr;
        out_clr_next  = out_clr_reg;
        cmd           = '0;
        cmd.asel      = AS_CELL;
        cmd.walk_src  = WI_ADD;
        cmd.status_val = ST_OK;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (clr_req_reg || cfg_wr)
                begin
                    cmd.clr_start = 1'b1;
                    clr_req_next  = 1'b0;
                    out_clr_next  = 1'b0;
                    state_next    = S_CLR;
                end
                else
                begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = S_DECIDE;
                    end
                end
            end
            S_CLR:
            begin
                cmd.asel       = AS_SWEEP;
                cmd.wr_en      = 1'b1;
                cmd.wr_zero    = 1'b1;
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = out_clr_reg ? S_DONE : S_IDLE;
                end
            end
            S_DECIDE:
            begin
                if (stat.req == REQ_CLEAR)
                begin
                    cmd.clr_start = 1'b1;
                    out_clr_next  = 1'b1;
                    state_next    = S_CLR;
                end
                else if (stat.bad_cell || (stat.req == REQ_ADD && stat.bad_add))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_BAD;
                    state_next     = S_DONE;
                end
                else if (stat.req == REQ_ADD)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = stat.empty_box ? S_DONE : S_CHKRD;
                end
                else
                begin
                    state_next = S_REFRD;
                end
            end
            S_REFRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_REFWT;
            end
            S_REFWT:
            begin
                cmd.ref_load = 1'b1;
                cmd.run_init = 1'b1;
                if (stat.req == REQ_REMOVE && stat.ref_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_EMPTY;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_RUNCHK;
                end
            end
            S_RUNCHK:
            begin
                if (stat.run_done)
                begin
                    cmd.set_found = 1'b1;
                    if (stat.req == REQ_REMOVE)
                    begin
                        cmd.walk_init = 1'b1;
                        cmd.walk_src  = WI_RUNS;
                        state_next    = S_RMRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (stat.run_more)
                begin
                    cmd.run_probe = 1'b1;
                    state_next    = S_RUNRD;
                end
                else
                begin
                    // no room this direction: treat as mismatch to advance
                    state_next = S_RUNWT;
                end
            end
            S_RUNRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RUNWT;
            end
            S_RUNWT:
            begin
                if (stat.run_more)
                begin
                    cmd.run_hit = 1'b1;
                end
                else
                begin
                    cmd.run_hit = 1'b1;
                end
                state_next = S_RUNCHK;
            end
            S_CHKRD:
            begin
                cmd.asel   = AS_WALK;
                cmd.rd_en  = 1'b1;
                state_next = S_CHKWT;
            end
            S_CHKWT:
            begin
                state_next = S_CHKCHK;
            end
            S_CHKCHK:
            begin
                if (stat.rd_nonzero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_OCCUPIED;
                    state_next     = S_DONE;
                end
                else if (stat.walk_last)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WRITE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_CHKRD;
                end
            end
            S_WRITE:
            begin
                cmd.asel  = AS_WALK;
                cmd.wr_en = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_RMRD:
            begin
                cmd.asel   = AS_WALK;
                cmd.rd_en  = 1'b1;
                state_next = S_RMWT;
            end
            S_RMWT:
            begin
                state_next = S_RMCHK;
            end
            S_RMCHK:
            begin
                cmd.asel = AS_WALK;
                if (stat.rd_eq_ref)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_zero = 1'b1;
                end
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_RMRD;
                end
            end
            S_DONE:
            begin
                cmd.out_load  = 1'b1;
                cmd.keep_runs = (stat.req == REQ_REMOVE || stat.req == REQ_LAYOUT)
                                && !out_clr_reg;
                out_clr_next  = 1'b0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("both sides open");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmd.wr_en)
        else $error("write while idle");
`endif
endmodule
`default_nettype wire

FILE: design/voxel_box_occupancy_grid.sv
// channel    | dir | handshake              | payload
// s_axis     | in  | s_axis_tvalid/tready   | tdata: request fields
// m_axis     | out | m_axis_tvalid/tready   | tdata: result fields
// grid_depth | in  | grid_depth_we          | grid_depth_wdata[3:0]
// One request at a time. Clear, reset and depth writes sweep every cell
// of the 2^(3*clog2(MAX_DEPTH)) store, one per cycle (512 at default),
// with input held off.
// Add: each box cell to check passes read, wait and check states, then each cell is written.
// Remove/layout: each run probe passes check, read and wait states, a run side with no room
// passes check and wait only, and remove adds read, wait and check per cell of the box.
// A result waits in the output register until taken.
`default_nettype none
module voxel_box_occupancy_grid
    import vbog_pkg::*;
#(
    parameter int MAX_DEPTH = 8,
    parameter int ID_BITS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic grid_depth_we,
    input  wire logic [3:0] grid_depth_wdata,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // req_type, cell_x, cell_y, cell_z, box_x, box_y, box_z, owner_id
    input  wire logic [((ID_BITS+23+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // status, found_id, origin_x/y/z, extent_x/y/z
    output logic [((ID_BITS+23+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW = ((ID_BITS + 23 + 7) / 8) * 8;
    logic [3:0] depth_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [ID_BITS+22:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (grid_depth_we)
        begin
            depth_reg <= grid_depth_wdata;
        end
    end

    vbog_ctrl u_ctrl (
        .clk, .rst_n,
        .cfg_wr(grid_depth_we),
        .s_axis_tvalid, .s_axis_tready,
        .m_axis_tvalid, .m_axis_tready,
        .stat, .cmd
    );

    vbog_datapath #(.MAX_DEPTH(MAX_DEPTH), .ID_BITS(ID_BITS)) u_dp (
        .clk, .rst_n,
        .grid_depth(depth_reg),
        .req_data(s_axis_tdata[ID_BITS+22:0]),
        .cmd, .stat, .result
    );

    assign m_axis_tdata = OW'(result);
endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import vbog_pkg::*;

    typedef struct {
        req_t        kind;
        bit [2:0]    cx, cy, cz;
        bit [3:0]    bx, by, bz;
        bit [15:0]   id;
    } request_t;

    typedef struct {
        status_t     st;
        bit [15:0]   found;
        bit [2:0]    ox, oy, oz;
        bit [3:0]    ex, ey, ez;
    } grid_result_t;

    class grid_scoreboard;
        bit [15:0]      owner[512];
        int unsigned    depth_reg;
        grid_result_t   awaited[$];
        int             errors;

        function void write_depth(bit [3:0] v);
            depth_reg = v;
            foreach (owner[i]) owner[i] = '0;
        endfunction

        function int unsigned used_depth();
            return depth_reg > 8 ? 8 : depth_reg;
        endfunction

        function int unsigned cell_index(int unsigned x, int unsigned y, int unsigned z);
            int unsigned d;
            d = used_depth();
            return (z * d + y) * d + x;
        endfunction

        // each axis run starts at the addressed cell and grows both ways
        function void runs_through(int unsigned c[3], output int unsigned org[3],
                                   output int unsigned ext[3]);
            int unsigned d, lo, hi;
            int unsigned p[3];
            bit [15:0] ref_id;
            d = used_depth();
            ref_id = owner[cell_index(c[0], c[1], c[2])];
            for (int a = 0; a < 3; a++)
            begin
                lo = c[a];
                hi = c[a];
                p = c;
                while (lo > 0)
                begin
                    p[a] = lo - 1;
                    if (owner[cell_index(p[0], p[1], p[2])] != ref_id) break;
                    lo--;
                end
                while (hi + 1 < d)
                begin
                    p[a] = hi + 1;
                    if (owner[cell_index(p[0], p[1], p[2])] != ref_id) break;
                    hi++;
                end
                org[a] = lo;
                ext[a] = hi - lo + 1;
            end
        endfunction

        function void note_request(request_t r);
            grid_result_t res;
            int unsigned d;
            int unsigned c[3], sz[3], org[3], ext[3];
            bit [15:0] ref_id;
            bit hit;
            res = '{ST_OK, 0, 0, 0, 0, 0, 0, 0};
            d = used_depth();
            c = '{r.cx, r.cy, r.cz};
            sz = '{r.bx, r.by, r.bz};
            org = '{0, 0, 0};
            ext = '{0, 0, 0};
            if (r.kind == REQ_CLEAR)
            begin
                foreach (owner[i]) owner[i] = '0;
            end
            else if (d == 0 || c[0] >= d || c[1] >= d || c[2] >= d)
                res.st = ST_BAD;
            else if (r.kind == REQ_ADD)
            begin
                if (r.id == 0 || c[0] + sz[0] > d || c[1] + sz[1] > d || c[2] + sz[2] > d)
                    res.st = ST_BAD;
                else
                begin
                    hit = 0;
                    for (int z = c[2]; z < c[2] + sz[2]; z++)
                        for (int y = c[1]; y < c[1] + sz[1]; y++)
                            for (int x = c[0]; x < c[0] + sz[0]; x++)
                                if (owner[cell_index(x, y, z)] != 0) hit = 1;
                    if (hit)
                        res.st = ST_OCCUPIED;
                    else
                        for (int z = c[2]; z < c[2] + sz[2]; z++)
                            for (int y = c[1]; y < c[1] + sz[1]; y++)
                                for (int x = c[0]; x < c[0] + sz[0]; x++)
                                    owner[cell_index(x, y, z)] = r.id;
                end
            end
            else if (r.kind == REQ_REMOVE)
            begin
                ref_id = owner[cell_index(c[0], c[1], c[2])];
                if (ref_id == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    runs_through(c, org, ext);
                    for (int z = org[2]; z < org[2] + ext[2]; z++)
                        for (int y = org[1]; y < org[1] + ext[1]; y++)
                            for (int x = org[0]; x < org[0] + ext[0]; x++)
                                if (owner[cell_index(x, y, z)] == ref_id)
                                    owner[cell_index(x, y, z)] = 0;
                    res.found = ref_id;
                end
            end
            else
            begin
                res.found = owner[cell_index(c[0], c[1], c[2])];
                runs_through(c, org, ext);
            end
            res.ox = 3'(org[0]);
            res.oy = 3'(org[1]);
            res.oz = 3'(org[2]);
            res.ex = 4'(ext[0]);
            res.ey = 4'(ext[1]);
            res.ez = 4'(ext[2]);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [39:0] t);
            grid_result_t e;
            if (awaited.size() == 0)
            begin
                $error("result with none pending: %h", t);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (t[1:0] !== e.st)
            begin
                $error("status expected %0d got %0d", e.st, t[1:0]); errors++;
            end
            if (t[17:2] !== e.found)
            begin
                $error("found_id expected %0h got %0h", e.found, t[17:2]); errors++;
            end
            if (t[20:18] !== e.ox)
            begin
                $error("origin_x expected %0d got %0d", e.ox, t[20:18]); errors++;
            end
            if (t[23:21] !== e.oy)
            begin
                $error("origin_y expected %0d got %0d", e.oy, t[23:21]); errors++;
            end
            if (t[26:24] !== e.oz)
            begin
                $error("origin_z expected %0d got %0d", e.oz, t[26:24]); errors++;
            end
            if (t[30:27] !== e.ex)
            begin
                $error("extent_x expected %0d got %0d", e.ex, t[30:27]); errors++;
            end
            if (t[34:31] !== e.ey)
            begin
                $error("extent_y expected %0d got %0d", e.ey, t[34:31]); errors++;
            end
            if (t[38:35] !== e.ez)
            begin
                $error("extent_z expected %0d got %0d", e.ez, t[38:35]); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        grid_depth_we;
    logic [3:0]  grid_depth_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    grid_scoreboard sb;
    bit calm;
    bit hold_req;
    int idle_cycles;

    voxel_box_occupancy_grid dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .grid_depth_we    (grid_depth_we),
        .grid_depth_wdata (grid_depth_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic send(request_t r);
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.id, r.bz, r.by, r.bx, r.cz, r.cy, r.cx, r.kind};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic ask(req_t k, int cx, int cy, int cz, int bx, int by, int bz, int id);
        request_t r;
        r = '{k, 3'(cx), 3'(cy), 3'(cz), 4'(bx), 4'(by), 4'(bz), 16'(id)};
        send(r);
    endtask

    task automatic drain();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic set_depth(bit [3:0] v);
        drain();
        repeat (20) @(posedge clk);
        grid_depth_we    <= 1'b1;
        grid_depth_wdata <= v;
        @(posedge clk);
        grid_depth_we    <= 1'b0;
        sb.write_depth(v);
    endtask

    function automatic request_t make_request(int unsigned d);
        request_t r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (d == 0 || roll < 7)
        begin
            // noise: any field value at all
            r.kind = req_t'($urandom_range(0, 3));
            r.cx = 3'($urandom); r.cy = 3'($urandom); r.cz = 3'($urandom);
            r.bx = 4'($urandom); r.by = 4'($urandom); r.bz = 4'($urandom);
            r.id = 16'($urandom);
            return r;
        end
        roll = $urandom_range(0, 99);
        r.kind = roll < 45 ? REQ_ADD : roll < 70 ? REQ_REMOVE : roll < 97 ? REQ_LAYOUT
                                                                            : REQ_CLEAR;
        r.cx = 3'($urandom_range(0, d - 1));
        r.cy = 3'($urandom_range(0, d - 1));
        r.cz = 3'($urandom_range(0, d - 1));
        if ($urandom_range(0, 19) == 0)
        begin
            r.bx = 4'($urandom_range(0, d - r.cx));
            r.by = 4'($urandom_range(0, d - r.cy));
            r.bz = 4'($urandom_range(0, d - r.cz));
        end
        else
        begin
            r.bx = 4'($urandom_range(1, (d - r.cx) < 3 ? d - r.cx : 3));
            r.by = 4'($urandom_range(1, (d - r.cy) < 3 ? d - r.cy : 3));
            r.bz = 4'($urandom_range(1, (d - r.cz) < 3 ? d - r.cz : 3));
        end
        // a small id pool makes neighboring boxes share ids
        r.id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 5));
        if (r.id == 0) r.id = 1;
        return r;
    endfunction

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            int hold_cnt;
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 20000)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        bit [3:0] depths[9] = '{8, 1, 3, 15, 2, 5, 0, 8, 4};
        sb = new();
        sb.write_depth(0);
        rst_n            = 1'b0;
        grid_depth_we    = 1'b0;
        grid_depth_wdata = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        calm     = 0;
        hold_req = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no grid yet
        ask(REQ_ADD, 0, 0, 0, 1, 1, 1, 1);
        ask(REQ_LAYOUT, 0, 0, 0, 0, 0, 0, 0);
        ask(REQ_CLEAR, 7, 7, 7, 15, 15, 15, 16'hffff);
        set_depth(8);
        ask(REQ_ADD, 0, 0, 0, 8, 8, 8, 16'hffff);
        ask(REQ_LAYOUT, 7, 7, 7, 0, 0, 0, 0);
        ask(REQ_ADD, 1, 1, 1, 1, 1, 1, 3);
        ask(REQ_REMOVE, 3, 3, 3, 0, 0, 0, 0);
        ask(REQ_REMOVE, 3, 3, 3, 0, 0, 0, 0);
        ask(REQ_LAYOUT, 4, 4, 4, 0, 0, 0, 0);
        ask(REQ_ADD, 2, 2, 2, 1, 1, 1, 0);
        ask(REQ_ADD, 2, 2, 2, 0, 3, 3, 9);
        ask(REQ_ADD, 5, 0, 0, 4, 1, 1, 9);
        ask(REQ_ADD, 0, 0, 0, 2, 1, 1, 5);
        ask(REQ_ADD, 0, 1, 0, 1, 2, 1, 5);
        ask(REQ_ADD, 0, 0, 0, 1, 1, 1, 6);
        ask(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0);
        ask(REQ_LAYOUT, 0, 2, 0, 0, 0, 0, 0);
        ask(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        set_depth(4);
        ask(REQ_ADD, 7, 0, 0, 1, 1, 1, 2);
        ask(REQ_REMOVE, 0, 4, 0, 0, 0, 0, 0);
        ask(REQ_LAYOUT, 0, 0, 5, 0, 0, 0, 0);
        ask(REQ_ADD, 3, 3, 3, 1, 1, 1, 16'h8000);
        ask(REQ_LAYOUT, 3, 3, 3, 0, 0, 0, 0);

        for (int ph = 0; ph < 9; ph++)
        begin
            set_depth(depths[ph]);
            calm = (ph == 2);
            for (int n = 0; n < 150; n++)
            begin
                if (ph == 4 && n == 20) hold_req = 1;
                if (ph == 5 && n == 75) drain();
                send(make_request(sb.used_depth()));
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
